>>> sv/hbw_pkg.sv
`default_nettype none
package hbw_pkg;

    localparam int COEF_W    = 48;
    localparam int COEF_NUM  = 8;
    localparam int CFG_IDX_W = 3;
    localparam logic signed [COEF_W-1:0] COEF_ONE = 48'sh0001_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_00 = 3'd0,
        COEF_01 = 3'd1,
        COEF_02 = 3'd2,
        COEF_10 = 3'd3,
        COEF_11 = 3'd4,
        COEF_12 = 3'd5,
        COEF_20 = 3'd6,
        COEF_21 = 3'd7
    } t_coef_idx;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam int X_W   = 10;
    localparam int Y_W   = 9;
    localparam int PIX_W = 24;
    localparam int CH_W  = 8;

    // projection and division widths
    localparam int PROD_W = 59;           // coef * coordinate
    localparam int SUM_W  = 61;           // X, Y, Z in Q.32
    localparam int FRAC   = 8;
    localparam int NUM_W  = SUM_W + FRAC; // |X| << 8
    localparam int QB     = 21;           // quotient bits kept
    localparam int OVF_SH = QB - FRAC;    // |X| >= Z << OVF_SH: far outside
    localparam int SX_W   = QB + 1;
    localparam int IX_W   = SX_W - FRAC;
    localparam int DIV_LAT = QB + 2;

    localparam int W_W    = 17;           // tap weight
    localparam int PRD_W  = CH_W + W_W;
    localparam int ACC_W  = PRD_W + 2;

    typedef struct packed {
        logic             cmd;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [PIX_W-1:0] pix;
    } t_item;

endpackage
`default_nettype wire

>>> sv/hbw_div.sv
`default_nettype none
module hbw_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [hbw_pkg::NUM_W-1:0]     i_num,
    input  wire logic                          i_neg,
    input  wire logic [hbw_pkg::SUM_W-1:0]     i_den,
    output logic signed [hbw_pkg::SX_W-1:0]    o_sq
);
    localparam int QB = hbw_pkg::QB;
    localparam int NW = hbw_pkg::NUM_W;
    localparam int DW = hbw_pkg::SUM_W;
    localparam int RW = DW + QB;

    logic [NW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic          r_neg [QB+1];
    logic [hbw_pkg::SX_W-1:0] mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int B = QB - k;
        logic [RW-1:0] dsh;
        logic [RW-1:0] rem_x;
        logic          take;
        always_comb begin
            dsh   = RW'(r_den[k-1]) << B;
            rem_x = RW'(r_rem[k-1]);
            take  = rem_x >= dsh;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? NW'(rem_x - dsh) : r_rem[k-1];
                r_q[k]   <= take ? (r_q[k-1] | (QB'(1) << B)) : r_q[k-1];
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // floor for negative numerators rounds the magnitude up
    always_comb begin
        mag = {1'b0, r_q[QB]} + hbw_pkg::SX_W'(r_neg[QB] && (r_rem[QB] != '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sq <= r_neg[QB] ? -$signed(mag) : $signed(mag);
        end
    end

endmodule
`default_nettype wire

>>> sv/homography_bilinear_warp.sv
// Perspective warp with bilinear sampling over a banked BGR source store.
// Input channel: i_valid / o_stall, word taken when i_valid and !o_stall.
//   i_command load writes one source pixel if in bounds (no output word);
//   sample projects (i_pos_x, i_pos_y) through the homography and returns
//   one blended BGR word.
// Output channel: o_valid / i_stall, word taken when o_valid and !i_stall.
// Config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index
//   selects a Q16.32 coefficient; write only while the block is idle.
// Throughput: one word per clock while the output is not stalled; loads
//   and samples freely mixed. A sample passes the projection stages, the
//   21-stage restoring divider, then addressing, store read and blend
//   stages.
// The store is four banks split by row and column parity, so the four taps
//   are read in the same cycle; loads write in that stage, keeping order.
// When the receiver stalls with a result waiting the whole pipe holds and
//   o_stall rises. Reset clears valids and coefficients (identity); store
//   contents are undefined until loaded.
`default_nettype none
module homography_bilinear_warp #(
    parameter int SRC_WIDTH  = 960,
    parameter int SRC_HEIGHT = 512
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_command,
    input  wire logic [hbw_pkg::X_W-1:0]           i_pos_x,
    input  wire logic [hbw_pkg::Y_W-1:0]           i_pos_y,
    input  wire logic [hbw_pkg::CH_W-1:0]          i_blue_in,
    input  wire logic [hbw_pkg::CH_W-1:0]          i_green_in,
    input  wire logic [hbw_pkg::CH_W-1:0]          i_red_in,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [hbw_pkg::CH_W-1:0]               o_blue_out,
    output logic [hbw_pkg::CH_W-1:0]               o_green_out,
    output logic [hbw_pkg::CH_W-1:0]               o_red_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hbw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hbw_pkg::COEF_W-1:0]        i_cfg_data
);
    localparam int HALF_W = (SRC_WIDTH + 1) / 2;
    localparam int HALF_H = (SRC_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int XBW = (HALF_W > 1) ? $clog2(HALF_W) : 1;
    localparam int YBW = (HALF_H > 1) ? $clog2(HALF_H) : 1;
    localparam int AW  = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int IX_W = hbw_pkg::IX_W;
    localparam int SUM_W = hbw_pkg::SUM_W;
    localparam int PROD_W = hbw_pkg::PROD_W;
    localparam int DIV_LAT = hbw_pkg::DIV_LAT;
    localparam int CH_W = hbw_pkg::CH_W;
    localparam logic signed [IX_W:0] W_S = (IX_W+1)'(SRC_WIDTH);
    localparam logic signed [IX_W:0] H_S = (IX_W+1)'(SRC_HEIGHT);

    logic en;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    // coefficients
    logic signed [hbw_pkg::COEF_W-1:0] r_coef [hbw_pkg::COEF_NUM];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hbw_pkg::COEF_NUM; i++) begin
                r_coef[i] <= (i == int'(hbw_pkg::COEF_00) || i == int'(hbw_pkg::COEF_11))
                             ? hbw_pkg::COEF_ONE : '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // S0: input register
    logic          r_v0;
    hbw_pkg::t_item r_it0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it0 <= '{cmd: i_command, x: i_pos_x, y: i_pos_y,
                       pix: {i_red_in, i_green_in, i_blue_in}};
        end
    end

    // S1: products
    logic          r_v1;
    hbw_pkg::t_item r_it1;
    logic signed [PROD_W-1:0] r_p1 [6];
    logic signed [PROD_W-1:0] xs, ys;
    assign xs = PROD_W'($signed({1'b0, r_it0.x}));
    assign ys = PROD_W'($signed({1'b0, r_it0.y}));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it1 <= r_it0;
            r_p1[0] <= PROD_W'(r_coef[hbw_pkg::COEF_00]) * xs;
            r_p1[1] <= PROD_W'(r_coef[hbw_pkg::COEF_01]) * ys;
            r_p1[2] <= PROD_W'(r_coef[hbw_pkg::COEF_10]) * xs;
            r_p1[3] <= PROD_W'(r_coef[hbw_pkg::COEF_11]) * ys;
            r_p1[4] <= PROD_W'(r_coef[hbw_pkg::COEF_20]) * xs;
            r_p1[5] <= PROD_W'(r_coef[hbw_pkg::COEF_21]) * ys;
        end
    end

    // S2: X, Y, Z
    logic          r_v2;
    hbw_pkg::t_item r_it2;
    logic signed [SUM_W-1:0] r_xq, r_yq, r_zq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it2 <= r_it1;
            r_xq <= SUM_W'(r_p1[0]) + SUM_W'(r_p1[1]) + SUM_W'(r_coef[hbw_pkg::COEF_02]);
            r_yq <= SUM_W'(r_p1[2]) + SUM_W'(r_p1[3]) + SUM_W'(r_coef[hbw_pkg::COEF_12]);
            r_zq <= SUM_W'(r_p1[4]) + SUM_W'(r_p1[5]) + SUM_W'(hbw_pkg::COEF_ONE);
        end
    end

    // divide setup
    logic [SUM_W-1:0] mag_x, mag_y;
    logic             out_any;
    always_comb begin
        mag_x = r_xq[SUM_W-1] ? SUM_W'(-r_xq) : SUM_W'(r_xq);
        mag_y = r_yq[SUM_W-1] ? SUM_W'(-r_yq) : SUM_W'(r_yq);
        out_any = r_zq[SUM_W-1] || (r_zq == '0)
               || ((SUM_W+hbw_pkg::OVF_SH)'(mag_x)
                   >= ((SUM_W+hbw_pkg::OVF_SH)'(r_zq) << hbw_pkg::OVF_SH))
               || ((SUM_W+hbw_pkg::OVF_SH)'(mag_y)
                   >= ((SUM_W+hbw_pkg::OVF_SH)'(r_zq) << hbw_pkg::OVF_SH));
    end

    logic signed [hbw_pkg::SX_W-1:0] sq_x, sq_y;
    hbw_div u_div_x (
        .i_clk (i_clk), .i_en (en),
        .i_num ({mag_x, hbw_pkg::FRAC'(0)}), .i_neg (r_xq[SUM_W-1]),
        .i_den (r_zq), .o_sq (sq_x)
    );
    hbw_div u_div_y (
        .i_clk (i_clk), .i_en (en),
        .i_num ({mag_y, hbw_pkg::FRAC'(0)}), .i_neg (r_yq[SUM_W-1]),
        .i_den (r_zq), .o_sq (sq_y)
    );

    logic           r_dv   [DIV_LAT];
    hbw_pkg::t_item r_dit  [DIV_LAT];
    logic           r_dout [DIV_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_dv[i] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v2;
            for (int i = 1; i < DIV_LAT; i++) r_dv[i] <= r_dv[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dit[0]  <= r_it2;
            r_dout[0] <= out_any;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dit[i]  <= r_dit[i-1];
                r_dout[i] <= r_dout[i-1];
            end
        end
    end

    // S3: taps per bank
    hbw_pkg::t_item it_d;
    logic signed [IX_W-1:0] ix, iy;
    logic [hbw_pkg::FRAC-1:0] fx, fy;
    logic signed [IX_W:0] xsel [4];
    logic signed [IX_W:0] ysel [4];
    logic [hbw_pkg::FRAC:0] wx [4];
    logic [hbw_pkg::FRAC:0] wy [4];
    logic                   tv [4];
    logic [XBW-1:0]         bx [4];
    logic [YBW-1:0]         by [4];
    logic                   ld_in;

    always_comb begin
        it_d = r_dit[DIV_LAT-1];
        ix = sq_x[hbw_pkg::SX_W-1:hbw_pkg::FRAC];
        iy = sq_y[hbw_pkg::SX_W-1:hbw_pkg::FRAC];
        fx = sq_x[hbw_pkg::FRAC-1:0];
        fy = sq_y[hbw_pkg::FRAC-1:0];
        ld_in = (32'(it_d.x) < SRC_WIDTH) && (32'(it_d.y) < SRC_HEIGHT);
        for (int b = 0; b < 4; b++) begin
            xsel[b] = (ix[0] == b[0]) ? (IX_W+1)'(ix) : (IX_W+1)'(ix) + (IX_W+1)'(1);
            ysel[b] = (iy[0] == b[1]) ? (IX_W+1)'(iy) : (IX_W+1)'(iy) + (IX_W+1)'(1);
            wx[b] = (ix[0] == b[0]) ? (9'd256 - 9'(fx)) : 9'(fx);
            wy[b] = (iy[0] == b[1]) ? (9'd256 - 9'(fy)) : 9'(fy);
            if (it_d.cmd == hbw_pkg::CMD_LOAD) begin
                tv[b] = ld_in && (it_d.x[0] == b[0]) && (it_d.y[0] == b[1]);
                bx[b] = XBW'(it_d.x >> 1);
                by[b] = YBW'(it_d.y >> 1);
            end else begin
                tv[b] = !r_dout[DIV_LAT-1]
                     && (xsel[b] >= 0) && (xsel[b] < W_S)
                     && (ysel[b] >= 0) && (ysel[b] < H_S);
                bx[b] = XBW'(xsel[b] >>> 1);
                by[b] = YBW'(ysel[b] >>> 1);
            end
        end
    end

    logic                      r_v3, r_cmd3;
    logic [hbw_pkg::PIX_W-1:0] r_pix3;
    logic                      r_tv3 [4];
    logic [XBW-1:0]            r_bx3 [4];
    logic [YBW-1:0]            r_by3 [4];
    logic [hbw_pkg::W_W-1:0]   r_w3  [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_dv[DIV_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd3 <= it_d.cmd;
            r_pix3 <= it_d.pix;
            for (int b = 0; b < 4; b++) begin
                r_tv3[b] <= tv[b];
                r_bx3[b] <= bx[b];
                r_by3[b] <= by[b];
                r_w3[b]  <= hbw_pkg::W_W'(wx[b]) * hbw_pkg::W_W'(wy[b]);
            end
        end
    end

    // S4: bank address
    logic                      r_v4, r_cmd4;
    logic [hbw_pkg::PIX_W-1:0] r_pix4;
    logic                      r_tv4 [4];
    logic [AW-1:0]             r_ad4 [4];
    logic [hbw_pkg::W_W-1:0]   r_w4  [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd4 <= r_cmd3;
            r_pix4 <= r_pix3;
            for (int b = 0; b < 4; b++) begin
                r_tv4[b] <= r_tv3[b];
                r_ad4[b] <= AW'(r_by3[b] * HALF_W) + AW'(r_bx3[b]);
                r_w4[b]  <= r_w3[b];
            end
        end
    end

    // S5: store banks; loads write here in item order
    logic                    r_v5, r_cmd5;
    logic                    r_tv5 [4];
    logic [hbw_pkg::W_W-1:0] r_w5  [4];
    logic [hbw_pkg::PIX_W-1:0] rd5 [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd5 <= r_cmd4;
            for (int b = 0; b < 4; b++) begin
                r_tv5[b] <= r_tv4[b];
                r_w5[b]  <= r_w4[b];
            end
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [hbw_pkg::PIX_W-1:0] r_mem [BANK_DEPTH];
        logic [hbw_pkg::PIX_W-1:0] r_rd;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_v4 && (r_cmd4 == hbw_pkg::CMD_LOAD) && r_tv4[b]) begin
                    r_mem[r_ad4[b]] <= r_pix4;
                end
                r_rd <= r_mem[r_ad4[b]];
            end
        end
        assign rd5[b] = r_rd;
    end

    // S6: weighted taps
    logic                      r_v6, r_cmd6;
    logic [hbw_pkg::PRD_W-1:0] r_pr6 [4][3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd6 <= r_cmd5;
            for (int b = 0; b < 4; b++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pr6[b][c] <= r_tv5[b]
                        ? hbw_pkg::PRD_W'(rd5[b][c*CH_W +: CH_W])
                          * hbw_pkg::PRD_W'(r_w5[b])
                        : '0;
                end
            end
        end
    end

    // S7: sum, round, saturate
    logic [hbw_pkg::ACC_W-1:0] acc [3];
    logic [hbw_pkg::ACC_W-17:0] rnd [3];
    logic [CH_W-1:0] ch [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = hbw_pkg::ACC_W'(r_pr6[0][c]) + hbw_pkg::ACC_W'(r_pr6[1][c])
                   + hbw_pkg::ACC_W'(r_pr6[2][c]) + hbw_pkg::ACC_W'(r_pr6[3][c])
                   + hbw_pkg::ACC_W'(32768);
            rnd[c] = acc[c][hbw_pkg::ACC_W-1:16];
            ch[c]  = (rnd[c] > (hbw_pkg::ACC_W-16)'(255)) ? 8'd255 : CH_W'(rnd[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_v6 && (r_cmd6 == hbw_pkg::CMD_SAMPLE);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_blue_out  <= ch[0];
            o_green_out <= ch[1];
            o_red_out   <= ch[2];
        end
    end

endmodule
`default_nettype wire

>>> sv/hbw_check.sv
`default_nettype none
module hbw_check (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_stall,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic [7:0] o_blue_out,
    input wire logic [7:0] o_green_out,
    input wire logic [7:0] o_red_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blue_out)
            && $stable(o_green_out) && $stable(o_red_out))
        else $error("stalled word changed");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("word valid after reset");

    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind homography_bilinear_warp hbw_check u_hbw_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .o_blue_out  (o_blue_out),
    .o_green_out (o_green_out),
    .o_red_out   (o_red_out)
);
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 960;
    localparam int H = 512;
    localparam int LAT = 40;
    localparam longint LIMIT = 2000000;
    localparam longint FAR = 64'd1 << 20;
    localparam int X_W       = hbw_pkg::X_W;
    localparam int Y_W       = hbw_pkg::Y_W;
    localparam int CH_W      = hbw_pkg::CH_W;
    localparam int PIX_W     = hbw_pkg::PIX_W;
    localparam int COEF_W    = hbw_pkg::COEF_W;
    localparam int COEF_NUM  = hbw_pkg::COEF_NUM;
    localparam int CFG_IDX_W = hbw_pkg::CFG_IDX_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_command;
    logic [X_W-1:0]       i_pos_x;
    logic [Y_W-1:0]       i_pos_y;
    logic [CH_W-1:0]      i_blue_in, i_green_in, i_red_in;
    logic                 o_valid;
    logic                 i_stall;
    logic [CH_W-1:0]      o_blue_out, o_green_out, o_red_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COEF_W-1:0]    i_cfg_data;

    homography_bilinear_warp #(.SRC_WIDTH(W), .SRC_HEIGHT(H)) uut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct packed {
        logic               is_cfg;
        logic               cmd;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [PIX_W-1:0]   pix;
        logic               typed;
        logic [PIX_W-1:0]   want;
        hbw_pkg::t_coef_idx idx;
        logic [COEF_W-1:0]  data;
    } t_row;

    logic signed [COEF_W-1:0] coef [COEF_NUM];
    logic [PIX_W-1:0] img [W*H];
    bit               img_set [W*H];
    logic [PIX_W-1:0] pending_pix [$];
    t_row             rows [$];
    int               errors = 0;
    longint           cycles = 0;
    bit               calm = 0;
    int               stall_left = 0;

    task automatic report(input string what, input logic [PIX_W-1:0] got,
                          input logic [PIX_W-1:0] want);
        errors++;
        $display("mismatch %s: got %06h want %06h at %0t", what, got, want, $realtime);
    endtask

    task automatic expect_word(input logic [PIX_W-1:0] w);
        pending_pix = {pending_pix, w};
    endtask

    // source position of a sample; far means every tap is outside
    function automatic void project(input int x, input int y, output longint ix,
                                    output longint iy, output int fx, output int fy,
                                    output bit far);
        longint xs, ys, z, v [2];
        longint unsigned mag, q, r;
        longint ip;
        ix = 0;
        iy = 0;
        fx = 0;
        fy = 0;
        xs = longint'(coef[hbw_pkg::COEF_00]) * x + longint'(coef[hbw_pkg::COEF_01]) * y
             + longint'(coef[hbw_pkg::COEF_02]);
        ys = longint'(coef[hbw_pkg::COEF_10]) * x + longint'(coef[hbw_pkg::COEF_11]) * y
             + longint'(coef[hbw_pkg::COEF_12]);
        z  = longint'(coef[hbw_pkg::COEF_20]) * x + longint'(coef[hbw_pkg::COEF_21]) * y
             + longint'(hbw_pkg::COEF_ONE);
        far = (z <= 0);
        if (far) return;
        v[0] = xs;
        v[1] = ys;
        for (int a = 0; a < 2; a++) begin
            mag = (v[a] < 0) ? -v[a] : v[a];
            q = mag / z;
            r = mag % z;
            if (q >= FAR) far = 1;
            if (v[a] >= 0) ip = q;
            else if (r == 0) ip = -longint'(q);
            else begin
                ip = -longint'(q) - 1;
                r = z - r;
            end
            for (int k = 0; k < 8; k++) begin
                r = r << 1;
                ip = ip * 2;
                if (r >= z) begin
                    r = r - z;
                    ip = ip + 1;
                end
            end
            if (a == 0) begin
                ix = ip >>> 8;
                fx = int'(ip & 255);
            end else begin
                iy = ip >>> 8;
                fy = int'(ip & 255);
            end
        end
    endfunction

    function automatic bit inside_img(longint x, longint y);
        return x >= 0 && x < W && y >= 0 && y < H;
    endfunction

    // first tap that would be read before it is loaded, or -1
    function automatic int missing_tap(int x, int y);
        longint ix, iy, tx, ty;
        int fx, fy;
        bit far;
        project(x, y, ix, iy, fx, fy, far);
        if (far) return -1;
        for (int t = 0; t < 4; t++) begin
            tx = ix + (t & 1);
            ty = iy + (t >> 1);
            if (inside_img(tx, ty) && !img_set[ty*W+tx]) return int'(ty*W + tx);
        end
        return -1;
    endfunction

    function automatic logic [PIX_W-1:0] blend(int x, int y);
        longint ix, iy, tx, ty;
        int fx, fy;
        bit far;
        logic [PIX_W-1:0] tap [4], res;
        longint unsigned w [4], acc;
        project(x, y, ix, iy, fx, fy, far);
        if (far) return '0;
        for (int t = 0; t < 4; t++) begin
            tx = ix + (t & 1);
            ty = iy + (t >> 1);
            tap[t] = inside_img(tx, ty) ? img[ty*W+tx] : '0;
        end
        w[0] = 64'((256 - fx) * (256 - fy));
        w[1] = 64'(fx * (256 - fy));
        w[2] = 64'((256 - fx) * fy);
        w[3] = 64'(fx * fy);
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int t = 0; t < 4; t++) acc += tap[t][8*ch +: 8] * w[t];
            acc = (acc + 32768) >> 16;
            res[8*ch +: 8] = (acc > 255) ? 8'hff : acc[7:0];
        end
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input logic cmd, input int x, input int y, input logic [PIX_W-1:0] pix,
                        input bit typed, input logic [PIX_W-1:0] want);
        int g;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_pos_x <= X_W'(x);
        i_pos_y <= Y_W'(y);
        {i_red_in, i_green_in, i_blue_in} <= pix;
        do @(posedge i_clk); while (o_stall);
        if (cmd == hbw_pkg::CMD_LOAD) begin
            if (x < W && y < H) begin
                img[y*W+x] = pix;
                img_set[y*W+x] = 1;
            end
        end else begin
            expect_word(typed ? want : blend(x, y));
        end
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // load whatever unwritten taps a sample would touch
    task automatic fill_taps(input int x, input int y);
        int m;
        m = missing_tap(x, y);
        while (m >= 0) begin
            send(hbw_pkg::CMD_LOAD, m % W, m / W, PIX_W'($urandom), 0, '0);
            m = missing_tap(x, y);
        end
    endtask

    task automatic sample_safe(input int x, input int y);
        fill_taps(x, y);
        send(hbw_pkg::CMD_SAMPLE, x, y, PIX_W'($urandom), 0, '0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_coef(input hbw_pkg::t_coef_idx idx, input logic [COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        coef[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic write_all(input longint c [COEF_NUM]);
        for (int i = 0; i < COEF_NUM; i++)
            write_coef(hbw_pkg::t_coef_idx'(i), c[i][COEF_W-1:0]);
    endtask

    function automatic longint q32(real r);
        return longint'(r * 4294967296.0);
    endfunction

    function automatic longint rnd_q(longint span);
        longint unsigned r;
        r = {$urandom, $urandom};
        return longint'(r % longint'(2 * span + 1)) - span;
    endfunction

    task automatic random_items(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) sample_safe($urandom_range(0, 48), $urandom_range(0, 48));
            else if (r < 75) sample_safe($urandom_range(0, 1023), $urandom_range(0, 511));
            else send(hbw_pkg::CMD_LOAD, $urandom_range(0, 1023), $urandom_range(0, 511),
                      PIX_W'($urandom), 0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) stall_left <= stall_left - 1;
        else if (!calm && $urandom_range(0, 99) < 15)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
        i_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pix.size() == 0) begin
                report("unexpected", {o_red_out, o_green_out, o_blue_out}, '0);
            end else begin
                logic [PIX_W-1:0] w;
                w = pending_pix.pop_front();
                if ({o_red_out, o_green_out, o_blue_out} !== w)
                    report("word", {o_red_out, o_green_out, o_blue_out}, w);
            end
        end
    end

    task automatic item_row(input logic cmd, input int x, input int y,
                            input logic [PIX_W-1:0] pix, input bit typed,
                            input logic [PIX_W-1:0] want);
        t_row r;
        r = '0;
        r.cmd = cmd; r.x = X_W'(x); r.y = Y_W'(y); r.pix = pix; r.typed = typed;
        r.want = want;
        rows = {rows, r};
    endtask

    task automatic cfg_row(input hbw_pkg::t_coef_idx idx, input longint val);
        t_row r;
        r = '0;
        r.is_cfg = 1; r.idx = idx; r.data = val[COEF_W-1:0];
        rows = {rows, r};
    endtask

    initial begin
        longint c [COEF_NUM];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = hbw_pkg::CMD_LOAD;
        i_pos_x = '0;
        i_pos_y = '0;
        {i_red_in, i_green_in, i_blue_in} = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = hbw_pkg::COEF_00;
        i_cfg_data = '0;
        for (int i = 0; i < COEF_NUM; i++) coef[i] = '0;
        coef[hbw_pkg::COEF_00] = hbw_pkg::COEF_ONE;
        coef[hbw_pkg::COEF_11] = hbw_pkg::COEF_ONE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        item_row(hbw_pkg::CMD_LOAD, 0, 0, 24'h000000, 0, '0);
        item_row(hbw_pkg::CMD_LOAD, 1, 0, 24'hffffff, 0, '0);
        item_row(hbw_pkg::CMD_LOAD, 0, 1, 24'h563412, 0, '0);
        item_row(hbw_pkg::CMD_LOAD, 1, 1, 24'hc35aa5, 0, '0);
        item_row(hbw_pkg::CMD_SAMPLE, 0, 0, '0, 1, 24'h000000);
        item_row(hbw_pkg::CMD_SAMPLE, 1, 0, 24'hffffff, 0, '0);
        item_row(hbw_pkg::CMD_LOAD, 959, 511, 24'h017f80, 0, '0);
        item_row(hbw_pkg::CMD_SAMPLE, 959, 511, '0, 1, 24'h017f80);
        item_row(hbw_pkg::CMD_LOAD, 1023, 511, 24'hffffff, 0, '0);
        item_row(hbw_pkg::CMD_SAMPLE, 1023, 511, 24'hffffff, 1, 24'h000000);
        item_row(hbw_pkg::CMD_SAMPLE, 960, 0, '0, 1, 24'h000000);
        cfg_row(hbw_pkg::COEF_02, 64'sd1 << 31);
        item_row(hbw_pkg::CMD_SAMPLE, 0, 0, '0, 0, '0);
        item_row(hbw_pkg::CMD_SAMPLE, 0, 1, '0, 0, '0);
        cfg_row(hbw_pkg::COEF_21, -q32(1.0));
        item_row(hbw_pkg::CMD_SAMPLE, 0, 1, '0, 1, 24'h000000);
        item_row(hbw_pkg::CMD_SAMPLE, 0, 5, '0, 1, 24'h000000);
        item_row(hbw_pkg::CMD_SAMPLE, 0, 0, '0, 0, '0);
        cfg_row(hbw_pkg::COEF_02, 0);
        cfg_row(hbw_pkg::COEF_21, 0);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                drain();
                write_coef(rows[i].idx, rows[i].data);
            end else begin
                if (rows[i].cmd == hbw_pkg::CMD_SAMPLE) fill_taps(rows[i].x, rows[i].y);
                send(rows[i].cmd, rows[i].x, rows[i].y, rows[i].pix,
                     rows[i].typed, rows[i].want);
            end
        end

        random_items(90);
        calm = 1;
        random_items(25);
        calm = 0;
        drain();

        c = '{q32(1.4138173), q32(0.72942251), q32(-413.27905), q32(-0.0022388131),
              q32(1.8361104), q32(-234.76155), q32(-0.0000044721410), q32(0.00074460846)};
        write_all(c);
        random_items(70);
        drain();

        for (int i = 0; i < COEF_NUM; i++) c[i] = 64'sh7fff_ffff_ffff;
        write_all(c);
        random_items(25);
        drain();
        for (int i = 0; i < COEF_NUM; i++) c[i] = -(64'sd1 <<< 47);
        write_all(c);
        random_items(25);
        drain();

        for (int p = 0; p < 4; p++) begin
            c[0] = q32(0.5) + rnd_q(64'sd1 << 32);
            c[1] = rnd_q(64'sd1 << 30);
            c[2] = rnd_q(64'sd40 << 32);
            c[3] = rnd_q(64'sd1 << 30);
            c[4] = q32(0.5) + rnd_q(64'sd1 << 32);
            c[5] = rnd_q(64'sd40 << 32);
            c[6] = rnd_q(64'sd1 << 23);
            c[7] = rnd_q(64'sd1 << 23);
            write_all(c);
            random_items(65);
            if (p == 1) drain();
            random_items(5);
            drain();
        end

        c = '{q32(1.0), 0, 0, 0, q32(1.0), 0, 0, 0};
        write_all(c);
        random_items(45);
        drain();

        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
